[design/ptcw_pkg.sv]
// Package for the pulse trigger and charge window block.
// Holds the beat types, register indexes, sizes and state codes.
// Depends on nothing; every design file imports it.
package ptcw_pkg;

  localparam int RECORD_LENGTH = 512;
  localparam int ADDR_W        = $clog2(RECORD_LENGTH);
  localparam int CNT_W         = ADDR_W + 1;
  localparam int DELAY_DEPTH   = 16;
  localparam int DL_W          = $clog2(DELAY_DEPTH);
  localparam int SAMPLE_W      = 13;
  localparam int RAW_W         = 12;
  localparam int FRAC_W        = 16;
  localparam int PROD_W        = FRAC_W + SAMPLE_W;
  localparam int DIFF_W        = 31;
  localparam int SUM_W         = 19;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 13'd4096;
  localparam logic signed [DIFF_W-1:0] BEST_RESET = -(31'sd1 <<< 30);

  localparam logic [CFG_IDX_W-1:0] REG_ARC_DELAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARC_FRACTION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_END    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_START   = 3'd4;

  typedef struct packed {
    logic [RAW_W-1:0] raw_sample;
    logic             last_sample;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] trig_pos;
    logic [SUM_W-1:0]  charge_full;
    logic [SUM_W-1:0]  charge_tail;
  } out_t;

  typedef struct packed {
    logic                push;
    logic                clear;
    logic [SAMPLE_W-1:0] x;
    logic [ADDR_W-1:0]   s;
  } trig_ctl_t;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_FLUSH = 5'b00010,
    ST_SUM   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

endpackage

[design/ptcw_trigger.sv]
// Amplitude-ratio trigger tracker: delay line, one multiply stage and a
// running first-maximum compare. Depends on ptcw_pkg.
module ptcw_trigger (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptcw_pkg::trig_ctl_t           ctl,
  input  logic [3:0]                    cfg_delay,
  input  logic [ptcw_pkg::FRAC_W-1:0]   cfg_frac,
  output logic [ptcw_pkg::ADDR_W-1:0]   best_index
);
  import ptcw_pkg::*;

  logic [SAMPLE_W-1:0]      dl_r [DELAY_DEPTH];
  logic [DL_W-1:0]          early_idx;
  logic [SAMPLE_W-1:0]      early;
  logic [PROD_W-1:0]        prod;
  logic signed [DIFF_W-1:0] diff_nxt;
  logic                     cand_nxt;
  logic signed [DIFF_W-1:0] diff_r;
  logic                     cand_r;
  logic [ADDR_W-1:0]        sidx_r;
  logic signed [DIFF_W-1:0] best_r;
  logic [ADDR_W-1:0]        best_idx_r;

  assign early_idx = ctl.s[DL_W-1:0] - DL_W'(cfg_delay);
  assign early     = (cfg_delay == 4'd0) ? ctl.x : dl_r[early_idx];
  assign prod      = PROD_W'(cfg_frac) * PROD_W'(ctl.x);
  assign diff_nxt  = $signed({3'b000, early, 15'd0}) - $signed({2'b00, prod});
  assign cand_nxt  = ctl.push && (ctl.s >= ADDR_W'(cfg_delay));

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      dl_r[ctl.s[DL_W-1:0]] <= ctl.x;
    end
    diff_r <= diff_nxt;
    sidx_r <= ctl.s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r     <= 1'b0;
      best_r     <= BEST_RESET;
      best_idx_r <= '0;
    end else if (ctl.clear) begin
      cand_r     <= 1'b0;
      best_r     <= BEST_RESET;
      best_idx_r <= '0;
    end else begin
      cand_r <= cand_nxt;
      if (cand_r && (diff_r > best_r)) begin
        best_r     <= diff_r;
        best_idx_r <= sidx_r;
      end
    end
  end

  assign best_index = best_idx_r;

endmodule

[design/pulse_trigger_and_charge_windows.sv]
// Top level: sample store, register file and charge window sequencer.
// Depends on ptcw_pkg and ptcw_trigger.
//
//   channel | ports                         | beat taken when
//   input   | start, busy, in_data          | start high and busy low
//   result  | out_valid, out_data           | out_valid high (one cycle)
//   config  | cfg_we, cfg_index, cfg_data   | cfg_we high
//
// Samples are taken one per cycle while the record loads. After the last
// sample the block is busy: it settles the trigger compare, makes one store
// read per window offset from the lower start offset to total_end_offset,
// drains the read and then gives the result beat.
// Reset is synchronous and leaves the block ready with default registers.
// The receiver cannot stall; the result is shown for exactly one cycle.
module pulse_trigger_and_charge_windows (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  ptcw_pkg::in_t                     in_data,
  output logic                              out_valid,
  output ptcw_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [ptcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptcw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ptcw_pkg::*;

  logic [3:0]          arc_delay_r;
  logic [FRAC_W-1:0]   arc_fraction_r;
  logic signed [6:0]   tot_start_r;
  logic [5:0]          tot_end_r;
  logic signed [6:0]   tail_start_r;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r;
  logic                accept;
  logic                store;
  logic [SAMPLE_W-1:0] x;
  logic [SAMPLE_W-1:0] mem [RECORD_LENGTH];
  logic [SAMPLE_W-1:0] rdata_r;

  logic signed [7:0]   off_r;
  logic signed [7:0]   first_off;
  logic signed [7:0]   tot_start_ext;
  logic signed [7:0]   tail_start_ext;
  logic signed [7:0]   end_ext;
  logic signed [CNT_W:0] addr;
  logic                addr_ok;
  logic                rd_en_r;
  logic                rd_tot_r;
  logic                rd_tail_r;
  logic [SUM_W-1:0]    tot_acc_r;
  logic [SUM_W-1:0]    tail_acc_r;
  logic [ADDR_W-1:0]   best_index;
  trig_ctl_t           tctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arc_delay_r    <= 4'd2;
      arc_fraction_r <= 16'd31130;
      tot_start_r    <= -7'sd9;
      tot_end_r      <= 6'd30;
      tail_start_r   <= 7'sd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ARC_DELAY:    arc_delay_r    <= cfg_data[3:0];
        REG_ARC_FRACTION: arc_fraction_r <= cfg_data[FRAC_W-1:0];
        REG_TOTAL_START:  tot_start_r    <= $signed(cfg_data[6:0]);
        REG_TOTAL_END:    tot_end_r      <= cfg_data[5:0];
        REG_TAIL_START:   tail_start_r   <= $signed(cfg_data[6:0]);
        default: ;
      endcase
    end
  end

  assign busy   = (state_r != ST_LOAD);
  assign accept = start && !busy;
  assign store  = accept && (count_r < CNT_W'(RECORD_LENGTH));
  assign x      = FULL_SCALE - {1'b0, in_data.raw_sample};

  assign tctl.push  = store;
  assign tctl.clear = (state_r == ST_DONE);
  assign tctl.x     = x;
  assign tctl.s     = count_r[ADDR_W-1:0];

  ptcw_trigger u_trigger (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (tctl),
    .cfg_delay  (arc_delay_r),
    .cfg_frac   (arc_fraction_r),
    .best_index (best_index)
  );

  assign tot_start_ext  = {tot_start_r[6], tot_start_r};
  assign tail_start_ext = {tail_start_r[6], tail_start_r};
  assign end_ext        = $signed({2'b00, tot_end_r});
  assign first_off      = (tot_start_ext < tail_start_ext) ? tot_start_ext : tail_start_ext;
  assign addr           = $signed({2'b00, best_index}) + $signed({{(CNT_W-7){off_r[7]}}, off_r});
  assign addr_ok        = !addr[CNT_W] && (addr[CNT_W-1:0] < count_r);

  always_ff @(posedge clk) begin
    if (store) begin
      mem[count_r[ADDR_W-1:0]] <= x;
    end
    rdata_r <= mem[addr[ADDR_W-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:  if (accept && in_data.last_sample) state_nxt = ST_FLUSH;
      ST_FLUSH: state_nxt = ST_SUM;
      ST_SUM:   if (off_r >= end_ext) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      rd_en_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_en_r <= (state_r == ST_SUM) && addr_ok;
      if (state_r == ST_DONE) begin
        count_r <= '0;
      end else if (store) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_tot_r  <= (off_r >= tot_start_ext) && (off_r <= end_ext);
    rd_tail_r <= (off_r >= tail_start_ext) && (off_r <= end_ext);
    if (state_r == ST_FLUSH) begin
      off_r      <= first_off;
      tot_acc_r  <= '0;
      tail_acc_r <= '0;
    end else begin
      if (state_r == ST_SUM) begin
        off_r <= off_r + 8'sd1;
      end
      if (rd_en_r && rd_tot_r) begin
        tot_acc_r <= tot_acc_r + SUM_W'(rdata_r);
      end
      if (rd_en_r && rd_tail_r) begin
        tail_acc_r <= tail_acc_r + SUM_W'(rdata_r);
      end
    end
  end

  assign out_valid            = (state_r == ST_DONE);
  assign out_data.trig_pos    = best_index;
  assign out_data.charge_full = tot_acc_r;
  assign out_data.charge_tail = tail_acc_r;

endmodule

[tb/tb_pulse_trigger_and_charge_windows.sv]
// Self-checking testbench for pulse_trigger_and_charge_windows: streams waveform
// records through the sample port and checks each trigger and charge beat.
// Depends on ptcw_pkg and the design top level; runs on its own.
`timescale 1ns / 100ps

module tb_pulse_trigger_and_charge_windows;
  import ptcw_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 140;
  localparam int PHASE_ITEMS   = 56;
  localparam int SUM_CEILING   = (1 << SUM_W) - 1;
  localparam int LAST_REG_IDX  = (1 << CFG_IDX_W) - 1;

  typedef enum int {WAVE_PULSE, WAVE_NOISE, WAVE_FLAT, WAVE_RAILS} wave_kind_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_t                   in_data = '0;
  logic                  out_valid;
  out_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pulse_trigger_and_charge_windows uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  in_t  pending_samples[$];
  out_t expected_windows[$];
  int   beats_in = 0;
  int   beats_retired = 0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;

  // Shadow registers and record state of the predictor.
  logic [3:0]          cfg_delay;
  logic [FRAC_W-1:0]   cfg_frac;
  logic signed [6:0]   cfg_total_start;
  logic [5:0]          cfg_total_end;
  logic signed [6:0]   cfg_tail_start;
  logic [SAMPLE_W-1:0] sample_mem [RECORD_LENGTH];
  logic [SAMPLE_W-1:0] delay_taps [DELAY_DEPTH];
  int                  rec_count;
  longint              best_diff;
  int                  best_idx;
  out_t                want;

  task automatic restart_record();
    rec_count = 0;
    best_diff = longint'(BEST_RESET);
    best_idx  = 0;
    for (int i = 0; i < DELAY_DEPTH; i++) delay_taps[i] = '0;
  endtask

  function automatic logic [SUM_W-1:0] window_charge(input int trig, input int from,
                                                     input int upto);
    int acc;
    int idx;
    acc = 0;
    for (int o = from; o <= upto; o++) begin
      idx = trig + o;
      if (idx >= 0 && idx < rec_count) acc += int'(sample_mem[idx]);
    end
    if (acc > SUM_CEILING) acc = SUM_CEILING;
    return SUM_W'(acc);
  endfunction

  task automatic absorb_sample(input in_t beat);
    int     x;
    int     d;
    longint early;
    longint diff;
    out_t   result;
    x = 4096 - int'(beat.raw_sample);
    d = int'(cfg_delay);
    if (d > DELAY_DEPTH - 1) d = DELAY_DEPTH - 1;
    if (rec_count < RECORD_LENGTH) begin
      sample_mem[rec_count] = SAMPLE_W'(x);
      if (rec_count >= d) begin
        early = (d == 0) ? longint'(x) : longint'(delay_taps[(rec_count - d) % DELAY_DEPTH]);
        diff = early * 32768 - longint'(cfg_frac) * longint'(x);
        if (diff > best_diff) begin
          best_diff = diff;
          best_idx  = rec_count;
        end
      end
      delay_taps[rec_count % DELAY_DEPTH] = SAMPLE_W'(x);
      rec_count++;
    end
    if (beat.last_sample) begin
      result.trig_pos    = ADDR_W'(best_idx);
      result.charge_full = window_charge(best_idx, int'(cfg_total_start), int'(cfg_total_end));
      result.charge_tail = window_charge(best_idx, int'(cfg_tail_start), int'(cfg_total_end));
      expected_windows.insert(expected_windows.size(), result);
      restart_record();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_delay       = 4'd2;
      cfg_frac        = 16'd31130;
      cfg_total_start = -7'sd9;
      cfg_total_end   = 6'd30;
      cfg_tail_start  = 7'sd16;
      for (int i = 0; i < RECORD_LENGTH; i++) sample_mem[i] = '0;
      restart_record();
    end else begin
      if (out_valid) begin
        if (expected_windows.size() == 0) begin
          $display("%0t: result beat with none expected, actual %h", $time, out_data);
          mismatch_count++;
        end else begin
          want = expected_windows.pop_front();
          if (out_data.trig_pos !== want.trig_pos) begin
            $display("%0t: trig_pos expected %0d actual %0d", $time,
                     want.trig_pos, out_data.trig_pos);
            mismatch_count++;
          end
          if (out_data.charge_full !== want.charge_full) begin
            $display("%0t: charge_full expected %0d actual %0d", $time,
                     want.charge_full, out_data.charge_full);
            mismatch_count++;
          end
          if (out_data.charge_tail !== want.charge_tail) begin
            $display("%0t: charge_tail expected %0d actual %0d", $time,
                     want.charge_tail, out_data.charge_tail);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        absorb_sample(in_data);
        beats_in++;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ARC_DELAY:    cfg_delay       = cfg_data[3:0];
          REG_ARC_FRACTION: cfg_frac        = cfg_data[FRAC_W-1:0];
          REG_TOTAL_START:  cfg_total_start = cfg_data[6:0];
          REG_TOTAL_END:    cfg_total_end   = cfg_data[5:0];
          REG_TAIL_START:   cfg_tail_start  = cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

  always @(negedge clk) begin
    if (beats_in != beats_retired) begin
      void'(pending_samples.pop_front());
      beats_retired++;
    end
    if (!rst_n) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
      in_data <= {12'($urandom), 1'($urandom)};
    end else if (pending_samples.size() > 0) begin
      start <= 1'b1;
      in_data <= pending_samples[0];
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 48);
        if ($urandom_range(0, 3) == 0) gap_left = 0;
        else if ($urandom_range(0, 15) == 0) gap_left = $urandom_range(8, 20);
        else gap_left = $urandom_range(1, 5);
      end
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_pulse_trigger_and_charge_windows failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_index <= CFG_IDX_W'($urandom);
    cfg_data  <= CFG_DATA_W'($urandom);
  endtask

  // Unused upper data bits carry noise; the block must ignore them.
  task automatic program_windows(input int delay, input int frac, input int tot_start,
                                 input int tot_end, input int tail_start);
    write_reg(REG_ARC_DELAY, {12'($urandom), 4'(delay)});
    write_reg(REG_ARC_FRACTION, 16'(frac));
    write_reg(REG_TOTAL_START, {9'($urandom), 7'(tot_start)});
    write_reg(REG_TOTAL_END, {10'($urandom), 6'(tot_end)});
    write_reg(REG_TAIL_START, {9'($urandom), 7'(tail_start)});
    write_reg(CFG_IDX_W'($urandom_range(int'(REG_TAIL_START) + 1, LAST_REG_IDX)),
              CFG_DATA_W'($urandom));
  endtask

  task automatic queue_record(input int len, input wave_kind_t kind);
    int base;
    int amp;
    int pos;
    int tau;
    int level;
    int raw;
    in_t beat;
    base  = $urandom_range(3900, 4095);
    amp   = $urandom_range(0, 3900);
    pos   = $urandom_range(0, len - 1);
    tau   = $urandom_range(1, 30);
    level = $urandom_range(0, 4095);
    for (int i = 0; i < len; i++) begin
      case (kind)
        WAVE_PULSE: begin
          raw = base - int'($urandom_range(0, 7));
          if (i >= pos) raw -= amp * tau / (tau + i - pos);
        end
        WAVE_FLAT:  raw = level;
        WAVE_RAILS: raw = (i % 2 == 0) ? 0 : 4095;
        default:    raw = $urandom_range(0, 4095);
      endcase
      if (raw < 0) raw = 0;
      beat.raw_sample  = RAW_W'(raw);
      beat.last_sample = (i == len - 1);
      pending_samples.insert(pending_samples.size(), beat);
    end
  endtask

  task automatic drain_and_settle();
    while (pending_samples.size() != 0 || expected_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int phase_items;
    int len;
    int pick;
    wave_kind_t kind;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    queue_record(1, WAVE_RAILS);
    queue_record(2, WAVE_PULSE);
    queue_record(12, WAVE_PULSE);
    queue_record(6, WAVE_FLAT);
    drain_and_settle();
    for (int p = 1; p <= 7; p++) begin
      case (p)
        1: program_windows(0, 65535, -63, 63, -63);
        2: program_windows(15, 0, 0, 0, 63);
        3: program_windows(1, 32768, -64, 63, 63);
        5: program_windows(2, 31130, -9, 30, 16);
        default: program_windows($urandom_range(0, 15), $urandom_range(0, 65535),
                                 $urandom_range(0, 127), $urandom_range(0, 63),
                                 $urandom_range(0, 127));
      endcase
      @(posedge clk);
      case (p)
        1: queue_record(3, WAVE_RAILS);
        2: queue_record(RECORD_LENGTH + 1, WAVE_PULSE);
        7: queue_record($urandom_range(RECORD_LENGTH + 2, RECORD_LENGTH + 18), WAVE_NOISE);
        default: ;
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        pick = $urandom_range(0, 9);
        if (pick < 6) kind = WAVE_PULSE;
        else if (pick < 8) kind = WAVE_NOISE;
        else if (pick == 8) kind = WAVE_FLAT;
        else kind = WAVE_RAILS;
        queue_record(len, kind);
        phase_items += len;
      end
      drain_and_settle();
    end
    if (mismatch_count == 0) begin
      $display("tb_pulse_trigger_and_charge_windows passed");
    end else begin
      $display("tb_pulse_trigger_and_charge_windows failed");
    end
    $finish;
  end

endmodule

[pulse_trigger_and_charge_windows.f]
design/ptcw_pkg.sv
design/ptcw_trigger.sv
design/pulse_trigger_and_charge_windows.sv
tb/tb_pulse_trigger_and_charge_windows.sv
